// ===== rtl/tsib_pkg.sv =====
// ----------------------------------------------------------------------------
// tsib_pkg: shared types and constants for the sorted pose buffer
// Field widths, result codes and helper types.
// ----------------------------------------------------------------------------
`default_nettype none
package tsib_pkg;
   localparam int DefaultDepth = 64;
   localparam int TimeW   = 48;
   localparam int EntW    = 32;
   localparam int PoseW   = 32;
   localparam int NumPose = 6;
   localparam int FracW   = 16;

   localparam logic [1:0] StatInserted = 2'd0;
   localparam logic [1:0] StatEvicted  = 2'd1;
   localparam logic [1:0] StatDropped  = 2'd2;

   localparam logic FuncInsert  = 1'b0;
   localparam logic FuncPredict = 1'b1;

   typedef logic [NumPose*PoseW-1:0] pose_vec_type;

   typedef struct packed {
      logic              start;
      logic [TimeW-1:0]  num;
      logic [TimeW-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FracW-1:0]  frac;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/tsib_frac_div.sv =====
// ----------------------------------------------------------------------------
// tsib_frac_div: iterative fraction divider
// Restoring division, one quotient bit per cycle: frac = (num<<16)/den,
// saturating to all ones when num >= den.
// ----------------------------------------------------------------------------
`default_nettype none
module tsib_frac_div
   import tsib_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);
   logic [TimeW:0]       rem_ff, rem_in;
   logic [TimeW-1:0]     den_ff, den_in;
   logic [FracW-1:0]     quo_ff, quo_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TimeW+1:0]     trial;
   logic [TimeW:0]       shifted;

   always_comb begin
      shifted = {rem_ff[TimeW-1:0], 1'b0};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         den_in  = div_req.den;
         rem_in  = {1'b0, div_req.num};
         cnt_in  = 5'(FracW);
         if (div_req.num >= div_req.den) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            quo_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!trial[TimeW+1]) begin
            rem_in = trial[TimeW:0];
            quo_in = {quo_ff[FracW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[FracW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.frac = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/timestamp_sorted_interp_buffer.sv =====
// ----------------------------------------------------------------------------
// timestamp_sorted_interp_buffer: sorted pose store with interpolation
// Sequencing: insert does a forward scan, then a read and a write per shifted
//   entry through the memory; predict does a backward scan, a forward scan,
//   a divider start and 16 quotient bits, then 6 lerp steps.
// Throughput: one request at a time; ready only in idle.
// Reset: synchronous; clears entry count, lag register and control state.
//   Memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module timestamp_sorted_interp_buffer
   import tsib_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [47:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // sample_time, entity_id, pos_x..ori_z, now_time (lowest first), 320 bits
   input  wire logic [319:0] req_tdata,
   // func
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // insert_status, found, out_pos_x..out_ori_z (lowest first), pad to 200
   output logic [199:0]      rsp_tdata
);
   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int EntryW = TimeW + EntW + NumPose*PoseW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_IFIND, ST_IRD, ST_IMOVE, ST_IWR,
      ST_PLO, ST_PHI, ST_PDIV, ST_PLERP, ST_PMUL, ST_RSP
   } state_type;

   logic [EntryW-1:0] mem [DEPTH];
   logic [EntryW-1:0] rd_data_ff;
   logic [IdxW-1:0]   rd_addr;
   logic              wr_en;
   logic [IdxW-1:0]   wr_addr;
   logic [EntryW-1:0] wr_data;

   state_type         state_ff;
   logic [CntW-1:0]   count_ff;
   logic [TimeW-1:0]  lag_ff;
   logic [TimeW-1:0]  t_ff;
   logic [EntW-1:0]   ent_ff;
   pose_vec_type      pose_ff;
   logic [TimeW-1:0]  target_ff;
   logic [CntW-1:0]   idx_ff;
   logic [CntW-1:0]   pos_ff;
   logic              pend_ff;
   logic [TimeW-1:0]  t0_ff;
   pose_vec_type      pose0_ff;
   pose_vec_type      pose1_ff;
   logic [2:0]        k_ff;
   logic [FracW-1:0]  frac_ff;
   logic signed [PoseW+FracW+1:0] prod_ff;
   logic signed [PoseW-1:0]       a_ff;
   logic [1:0]        status_ff;
   logic              found_ff;
   pose_vec_type      out_ff;
   logic              rsp_valid_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   tsib_frac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   logic [TimeW-1:0] rd_time;
   logic [EntW-1:0]  rd_ent;
   pose_vec_type     rd_pose;
   assign rd_time = rd_data_ff[TimeW-1:0];
   assign rd_ent  = rd_data_ff[TimeW +: EntW];
   assign rd_pose = rd_data_ff[TimeW+EntW +: NumPose*PoseW];

   logic full;
   assign full = (count_ff == CntW'(DEPTH));

   // Address the port from the sequencer.
   always_comb begin
      rd_addr = idx_ff[IdxW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[IdxW-1:0];
      wr_data = rd_data_ff;
      if (state_ff == ST_IMOVE) begin
         wr_en = 1'b1;
         if (full) wr_addr = IdxW'(idx_ff - 1'b1);
         else      wr_addr = IdxW'(idx_ff + 1'b1);
      end else if (state_ff == ST_IWR) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff[IdxW-1:0];
         wr_data = {pose_ff, ent_ff, t_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   logic signed [PoseW-1:0]        a_sel;
   logic signed [PoseW:0]          diff;
   logic signed [PoseW+FracW+1:0]  prod_in;
   logic signed [PoseW+FracW+1:0]  q;
   logic [2:0] k_sel;
   assign k_sel = k_ff;
   always_comb begin
      a_sel   = pose0_ff[k_sel*PoseW +: PoseW];
      diff    = {pose1_ff[k_sel*PoseW+PoseW-1], pose1_ff[k_sel*PoseW +: PoseW]}
              - {a_sel[PoseW-1], a_sel};
      prod_in = diff * $signed({1'b0, frac_ff});
      q       = prod_ff >>> FracW;
   end

   logic phi_hit;
   assign phi_hit = (state_ff == ST_PHI) && pend_ff && (rd_ent == ent_ff);

   always_ff @(posedge clock) begin
      if (reset) div_req.start <= 1'b0;
      else       div_req.start <= phi_hit;
      if (phi_hit) begin
         div_req.num <= target_ff - t0_ff;
         div_req.den <= rd_time - t0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) lag_ff <= csr_wr_data;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  t_ff      <= req_tdata[47:0];
                  ent_ff    <= req_tdata[79:48];
                  pose_ff   <= req_tdata[271:80];
                  target_ff <= (req_tdata[319:272] > lag_ff) ?
                               req_tdata[319:272] - lag_ff : '0;
                  status_ff <= StatInserted;
                  found_ff  <= 1'b0;
                  out_ff    <= '0;
                  pend_ff   <= 1'b0;
                  if (req_tuser == FuncInsert) begin
                     idx_ff   <= '0;
                     pos_ff   <= count_ff;
                     state_ff <= ST_IFIND;
                  end else begin
                     idx_ff   <= count_ff - 1'b1;
                     state_ff <= ST_PLO;
                  end
               end
            end
            // Forward scan: idx addresses, pend marks rd_data holds idx-1.
            ST_IFIND: begin
               if (pend_ff && rd_time >= t_ff) begin
                  pos_ff  <= idx_ff - 1'b1;
                  pend_ff <= 1'b0;
                  idx_ff  <= '0;
                  state_ff <= ST_IRD;
               end else if (idx_ff >= count_ff) begin
                  pos_ff  <= count_ff;
                  pend_ff <= 1'b0;
                  idx_ff  <= '0;
                  state_ff <= ST_IRD;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + 1'b1;
               end
            end
            ST_IRD: begin
               if (full) begin
                  if (pos_ff == '0) begin
                     status_ff <= StatDropped;
                     state_ff  <= ST_RSP;
                  end else begin
                     status_ff <= StatEvicted;
                     pos_ff    <= pos_ff - 1'b1;
                     if (pos_ff == CntW'(1)) state_ff <= ST_IWR;
                     else begin
                        idx_ff <= CntW'(1);
                        state_ff <= ST_IMOVE;
                        pend_ff <= 1'b0;
                     end
                  end
               end else if (pos_ff == count_ff) begin
                  state_ff <= ST_IWR;
               end else begin
                  idx_ff  <= count_ff - 1'b1;
                  pend_ff <= 1'b0;
                  state_ff <= ST_IMOVE;
               end
            end
            // Each moved entry is read, then written to its neighbouring slot.
            ST_IMOVE: begin
               if (!pend_ff) begin
                  pend_ff <= 1'b1;
                  state_ff <= ST_IMOVE;
               end else begin
                  pend_ff <= 1'b0;
                  if (full) begin
                     if (idx_ff == pos_ff) state_ff <= ST_IWR;
                     else idx_ff <= idx_ff + 1'b1;
                  end else begin
                     if (idx_ff == pos_ff) state_ff <= ST_IWR;
                     else idx_ff <= idx_ff - 1'b1;
                  end
               end
            end
            ST_IWR: begin
               if (!full) count_ff <= count_ff + 1'b1;
               state_ff <= ST_RSP;
            end
            // Backward scan for the lower sample.
            ST_PLO: begin
               if (pend_ff && rd_time < target_ff && rd_ent == ent_ff) begin
                  t0_ff    <= rd_time;
                  pose0_ff <= rd_pose;
                  idx_ff   <= idx_ff + 2'd2;
                  pend_ff  <= 1'b0;
                  state_ff <= ST_PHI;
               end else if (idx_ff == '1 || (pend_ff && idx_ff == CntW'(DEPTH) - 1'b1)
                            || count_ff == '0) begin
                  state_ff <= ST_RSP;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff - 1'b1;
               end
            end
            ST_PHI: begin
               if (phi_hit) begin
                  pose1_ff <= rd_pose;
                  state_ff <= ST_PDIV;
               end else if (idx_ff >= count_ff) begin
                  state_ff <= ST_RSP;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff  <= idx_ff + 1'b1;
               end
            end
            ST_PDIV: begin
               if (div_rsp.done) begin
                  frac_ff  <= div_rsp.frac;
                  k_ff     <= '0;
                  state_ff <= ST_PLERP;
               end
            end
            ST_PLERP: begin
               prod_ff  <= prod_in;
               a_ff     <= a_sel;
               state_ff <= ST_PMUL;
            end
            ST_PMUL: begin
               out_ff[k_ff*PoseW +: PoseW] <= PoseW'(a_ff + q);
               if (k_ff == 3'(NumPose-1)) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_RSP;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_PLERP;
               end
            end
            ST_RSP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
               end else if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff, found_ff, status_ff};

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH)) else $error("entry count overflow");
   ap_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_RSP) else $error("response outside ST_RSP");
   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accept while busy");
endmodule
`default_nettype wire
